>>> hw/rtl/lpbm_pkg.sv
// Shared types and constants of the LRU page buffer manager.
// No dependencies; lpbm_if and the top level import this package.
package lpbm_pkg;

    localparam int CFG_W   = 7;
    localparam int KIND_W  = 2;
    localparam int FRAME_W = 6;

    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FETCH     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Division by five through a reciprocal: floor(x * 1639 / 8192) == x / 5 for x <= 2048.
    localparam int EVICT_MUL   = 1639;
    localparam int EVICT_SHIFT = 13;

endpackage

>>> hw/rtl/lpbm_if.sv
// Request and result channels of the LRU page buffer manager.
// Depends on lpbm_pkg for field widths.
interface lpbm_req_if #(parameter int PAGE_ID_BITS = 32);
    import lpbm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [PAGE_ID_BITS-1:0] page_id;

    modport source (output valid, output command, output page_id, input ready);
    modport sink   (input valid, input command, input page_id, output ready);
endinterface

interface lpbm_res_if #(parameter int PAGE_ID_BITS = 32);
    import lpbm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [PAGE_ID_BITS-1:0] out_page;
    logic [FRAME_W-1:0]      frame;
    logic                    hit;
    logic                    last;

    modport source (output valid, output kind, output out_page, output frame,
                    output hit, output last, input ready);
    modport sink   (input valid, input kind, input out_page, input frame,
                    input hit, input last, output ready);
endinterface

>>> hw/rtl/lpbm_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read data.
// No dependencies.
module lpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/lru_page_buffer_manager_top.sv
// Top level of the LRU page buffer manager: control sequencer and state memories.
// Depends on lpbm_pkg, lpbm_if and lpbm_ram.
//
//  channel   | direction | moves one word of
//  ----------+-----------+-----------------------------------------------
//  req       | in        | command, page_id
//  res       | out       | kind, out_page, frame, hit, last
//  cfg_we    | in        | active_frames (write only, no handshake)
//
// A request scans the frame table, one frame a cycle, up to the matching or last active frame.
// A hit on the most recent frame then goes straight to the done word; any other hit first
// relinks the list (a read and two writes), then emits it. A miss evicts pages if the free FIFO
// is empty and then takes a free frame, in steps on the single ports of the memories.
// After reset and after every configuration write a clearing pass over all MAX_FRAMES frames
// runs, during which req.ready stays low. A stalled result is held in the output register; the
// next request is accepted while it waits, and the sequencer stalls only when it must emit.
module lru_page_buffer_manager_top #(
    parameter int MAX_FRAMES   = 64,
    parameter int PAGE_ID_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lpbm_pkg::CFG_W-1:0]  cfg_wdata,
    lpbm_req_if.sink                    req,
    lpbm_res_if.source                  res
);
    import lpbm_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int AW = $clog2(MAX_FRAMES + 1);
    localparam int PB = PAGE_ID_BITS;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_HIT_RD, S_HIT_W1, S_HIT_W2, S_MISS, S_MISS_F,
        S_EV_RD, S_EV_OUT, S_POP_RD, S_POP_W, S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   active_reg, active_next;
    logic [AW-1:0]   evict_reg, evict_next;
    logic [FW-1:0]   idx_reg, idx_next;
    logic            cmd_reg, cmd_next;
    logic [PB-1:0]   page_reg, page_next;
    logic [FW-1:0]   scan_reg, scan_next;
    logic [FW-1:0]   chk_reg, chk_next;
    logic            pend_reg, pend_next;
    logic [FW-1:0]   frm_reg, frm_next;
    logic            hit_reg, hit_next;
    logic [FW-1:0]   head_reg, head_next;
    logic [FW-1:0]   tail_reg, tail_next;
    logic [AW-1:0]   len_reg, len_next;
    logic [FW-1:0]   rd_reg, rd_next;
    logic [AW-1:0]   count_reg, count_next;
    logic [AW-1:0]   evcnt_reg, evcnt_next;

    logic              ov_reg, ov_next;
    logic [KIND_W-1:0] okind_reg, okind_next;
    logic [PB-1:0]     opage_reg, opage_next;
    logic [FRAME_W-1:0] oframe_reg, oframe_next;
    logic              ohit_reg, ohit_next;
    logic              olast_reg, olast_next;

    logic          pg_we, nx_we, pv_we, ff_we;
    logic [FW-1:0] pg_waddr, nx_waddr, pv_waddr, ff_waddr;
    logic [PB:0]   pg_wdata, pg_rdata;
    logic [FW-1:0] nx_wdata, pv_wdata, ff_wdata;
    logic [FW-1:0] pg_raddr, lk_raddr;
    logic [FW-1:0] nx_rdata, pv_rdata, ff_rdata;

    logic              load_ok;
    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [PB-1:0]     e_page;
    logic [FW-1:0]     e_frame;
    logic              e_hit;
    logic              e_last;

    logic [AW+12:0] ev_prod;
    logic [AW-1:0]  ev_quot;
    logic [AW:0]    push_sum;
    logic [FW-1:0]  push_addr;
    logic [FW-1:0]  rd_inc;
    logic [AW-1:0]  cfg_clamped;

    // Each frame table word is {used, page}.
    lpbm_ram #(.WIDTH(PB + 1), .DEPTH(MAX_FRAMES)) u_page_ram (
        .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
        .raddr(pg_raddr), .rdata(pg_rdata));
    lpbm_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(lk_raddr), .rdata(nx_rdata));
    lpbm_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(lk_raddr), .rdata(pv_rdata));
    lpbm_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_fifo_ram (
        .clk(clk), .we(ff_we), .waddr(ff_waddr), .wdata(ff_wdata),
        .raddr(rd_reg), .rdata(ff_rdata));

    assign ev_prod = (AW + 13)'(active_reg) * (AW + 13)'(EVICT_MUL);
    assign ev_quot = ev_prod[AW+12:EVICT_SHIFT];

    assign push_sum  = (AW + 1)'(rd_reg) + (AW + 1)'(count_reg);
    assign push_addr = (push_sum >= (AW + 1)'(MAX_FRAMES))
                       ? FW'(push_sum - (AW + 1)'(MAX_FRAMES)) : FW'(push_sum);
    assign rd_inc    = (rd_reg == FW'(MAX_FRAMES - 1)) ? '0 : rd_reg + 1'b1;

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_clamped = AW'(1);
        end
        else if (32'(cfg_wdata) > MAX_FRAMES)
        begin
            cfg_clamped = AW'(MAX_FRAMES);
        end
        else
        begin
            cfg_clamped = AW'(cfg_wdata);
        end
    end

    assign load_ok   = !ov_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        evict_next  = evict_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        page_next   = page_reg;
        scan_next   = scan_reg;
        chk_next    = chk_reg;
        pend_next   = pend_reg;
        frm_next    = frm_reg;
        hit_next    = hit_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        len_next    = len_reg;
        rd_next     = rd_reg;
        count_next  = count_reg;
        evcnt_next  = evcnt_reg;

        pg_we = 1'b0; pg_waddr = tail_reg; pg_wdata = '0;
        nx_we = 1'b0; nx_waddr = frm_reg;  nx_wdata = head_reg;
        pv_we = 1'b0; pv_waddr = head_reg; pv_wdata = frm_reg;
        ff_we = 1'b0; ff_waddr = push_addr; ff_wdata = tail_reg;
        pg_raddr = (state_reg == S_SCAN) ? scan_reg : tail_reg;
        lk_raddr = (state_reg == S_HIT_RD) ? frm_reg : tail_reg;

        emit    = 1'b0;
        e_kind  = KIND_DONE;
        e_page  = page_reg;
        e_frame = frm_reg;
        e_hit   = 1'b0;
        e_last  = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                pg_we    = 1'b1;
                pg_waddr = idx_reg;
                ff_we    = 1'b1;
                ff_waddr = idx_reg;
                ff_wdata = idx_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == FW'(MAX_FRAMES - 1))
                begin
                    state_next = S_IDLE;
                    rd_next    = '0;
                    count_next = active_reg;
                    len_next   = '0;
                    head_next  = '0;
                    tail_next  = '0;
                    evict_next = (ev_quot == '0) ? AW'(1) : ev_quot;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    page_next  = req.page_id;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pend_reg && pg_rdata[PB] && (pg_rdata[PB-1:0] == page_reg))
                begin
                    frm_next   = chk_reg;
                    hit_next   = 1'b1;
                    state_next = (chk_reg == head_reg) ? S_DONE : S_HIT_RD;
                end
                else if (pend_reg && (AW'(chk_reg) == active_reg - 1'b1))
                begin
                    hit_next   = 1'b0;
                    state_next = S_MISS;
                end
                else
                begin
                    chk_next  = scan_reg;
                    pend_next = 1'b1;
                    if (AW'(scan_reg) != active_reg - 1'b1)
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            S_HIT_RD:
            begin
                state_next = S_HIT_W1;
            end
            S_HIT_W1:
            begin
                // Unlink: the newer neighbor takes the older one as its next.
                nx_we    = 1'b1;
                nx_waddr = pv_rdata;
                nx_wdata = nx_rdata;
                if (frm_reg != tail_reg)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                end
                else
                begin
                    tail_next = pv_rdata;
                end
                state_next = S_HIT_W2;
            end
            S_HIT_W2:
            begin
                nx_we      = 1'b1;
                pv_we      = 1'b1;
                head_next  = frm_reg;
                state_next = S_DONE;
            end
            S_MISS:
            begin
                state_next = S_MISS_F;
            end
            S_MISS_F:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    emit    = load_ok;
                    e_kind  = KIND_FETCH;
                    e_frame = (count_reg != '0) ? ff_rdata : tail_reg;
                end
                if ((cmd_reg == CMD_WRITE) || load_ok)
                begin
                    if (count_reg == '0)
                    begin
                        evcnt_next = evict_reg;
                        state_next = S_EV_RD;
                    end
                    else
                    begin
                        state_next = S_POP_RD;
                    end
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_OUT;
            end
            S_EV_OUT:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_WRITEBACK;
                    e_page     = pg_rdata[PB-1:0];
                    e_frame    = tail_reg;
                    pg_we      = 1'b1;
                    pg_wdata   = {1'b0, pg_rdata[PB-1:0]};
                    ff_we      = 1'b1;
                    count_next = count_reg + 1'b1;
                    tail_next  = pv_rdata;
                    len_next   = len_reg - 1'b1;
                    evcnt_next = evcnt_reg - 1'b1;
                    if ((evcnt_reg == AW'(1)) || (len_reg == AW'(1)))
                    begin
                        state_next = S_POP_RD;
                    end
                    else
                    begin
                        state_next = S_EV_RD;
                    end
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_W;
            end
            S_POP_W:
            begin
                pg_we      = 1'b1;
                pg_waddr   = ff_rdata;
                pg_wdata   = {1'b1, page_reg};
                rd_next    = rd_inc;
                count_next = count_reg - 1'b1;
                frm_next   = ff_rdata;
                head_next  = ff_rdata;
                len_next   = len_reg + 1'b1;
                if (len_reg == '0)
                begin
                    tail_next = ff_rdata;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = ff_rdata;
                    pv_we    = 1'b1;
                    pv_wdata = ff_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_ok)
                begin
                    emit       = 1'b1;
                    e_hit      = hit_reg;
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
                idx_next   = '0;
            end
        endcase

        // A configuration write empties the pool and restarts the clearing pass.
        if (cfg_we)
        begin
            active_next = cfg_clamped;
            idx_next    = '0;
            state_next  = S_INIT;
        end

        ov_next     = ov_reg;
        okind_next  = okind_reg;
        opage_next  = opage_reg;
        oframe_next = oframe_reg;
        ohit_next   = ohit_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            ov_next     = 1'b1;
            okind_next  = e_kind;
            opage_next  = e_page;
            oframe_next = FRAME_W'(e_frame);
            ohit_next   = e_hit;
            olast_next  = e_last;
        end
        else if (res.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            active_reg <= AW'(MAX_FRAMES);
            evict_reg  <= AW'(1);
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            len_reg    <= '0;
            rd_reg     <= '0;
            count_reg  <= '0;
            evcnt_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            evict_reg  <= evict_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            len_reg    <= len_next;
            rd_reg     <= rd_next;
            count_reg  <= count_next;
            evcnt_reg  <= evcnt_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        page_reg   <= page_next;
        scan_reg   <= scan_next;
        chk_reg    <= chk_next;
        frm_reg    <= frm_next;
        hit_reg    <= hit_next;
        okind_reg  <= okind_next;
        opage_reg  <= opage_next;
        oframe_reg <= oframe_next;
        ohit_reg   <= ohit_next;
        olast_reg  <= olast_next;
    end

    assign res.valid    = ov_reg;
    assign res.kind     = okind_reg;
    assign res.out_page = opage_reg;
    assign res.frame    = oframe_reg;
    assign res.hit      = ohit_reg;
    assign res.last     = olast_reg;

    // Every active frame is either on the LRU list or in the free FIFO between requests.
    a_frames_conserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        ((AW + 1)'(len_reg) + (AW + 1)'(count_reg) == (AW + 1)'(active_reg)))
        else $error("frame count lost between LRU list and free FIFO");

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_OUT) |-> (len_reg != '0) && (count_reg != AW'(MAX_FRAMES)))
        else $error("eviction with an empty LRU list");

    a_hit_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ohit_reg) |-> (okind_reg == KIND_DONE) && olast_reg)
        else $error("hit flag on a word that is not the done word");

    a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && olast_reg) |-> (okind_reg == KIND_DONE))
        else $error("last flag on a word that is not the done word");

endmodule
